/* design/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the delta timer queue
// Field widths, operation and result codes, controller states, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned OWNER_W     = 8;
  localparam int unsigned KIND_W      = 2;
  // most expiries reported for one tick
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS);

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    RK_ACCEPTED = 2'd0,
    RK_FULL     = 2'd1,
    RK_EXPIRED  = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_REJECT,
    ST_EXPIRE
  } dtq_state_e;

  // controller -> datapath
  typedef struct packed {
    logic         load_insert;
    logic         load_tick;
    logic         walk_step;
    logic         pop;
    logic         emit;
    result_kind_e emit_kind;
    logic         emit_last;
  } dtq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_done;
    logic head_zero;
    logic more_expire;
    logic out_free;
  } dtq_sts_t;

endpackage

/* design/dtq_if.sv */
// ----------------------------------------------------------------------------
// dtq_in_if / dtq_out_if: request and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dtq_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] delay_ticks;
  logic [7:0]  owner_tag;

  modport source (output valid, output operation, output delay_ticks,
                  output owner_tag, input ready);
  modport sink   (input valid, input operation, input delay_ticks,
                  input owner_tag, output ready);
endinterface

interface dtq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] woken_owner;
  logic       last_result;

  modport source (output valid, output result_kind, output woken_owner,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input woken_owner,
                  input last_result, output ready);
endinterface

/* design/dtq_datapath.sv */
// ----------------------------------------------------------------------------
// dtq_datapath: delta list storage, insert walk and result register
// The list sits in registers with the head at entry 0. An insert walk
// rotates the list once through the head, taking off deltas ahead of the
// new entry and dropping the new entry in at the tail at the right moment.
// ----------------------------------------------------------------------------
module dtq_datapath
  import dtq_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtq_cmd_t           cmd_i,
  output dtq_sts_t           sts_o,
  input  logic [DELAY_W-1:0] delay_ticks_i,
  input  logic [OWNER_W-1:0] owner_tag_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [KIND_W-1:0]  result_kind_o,
  output logic [OWNER_W-1:0] woken_owner_o,
  output logic               last_result_o
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FullCount = CW'(ENTRIES);

  logic [DELAY_W-1:0] delta_q [ENTRIES];
  logic [DELAY_W-1:0] delta_d [ENTRIES];
  logic [OWNER_W-1:0] owner_q [ENTRIES];
  logic [OWNER_W-1:0] owner_d [ENTRIES];
  logic [DELAY_W-1:0] nxt_delta [ENTRIES];
  logic [OWNER_W-1:0] nxt_owner [ENTRIES];

  logic [CW-1:0]      cnt_q, cnt_d, k_q, k_d, orig_q, orig_d;
  logic [DELAY_W-1:0] rem_q, rem_d;
  logic [OWNER_W-1:0] own_q, own_d;
  logic               ins_q, ins_d, adj_q, adj_d;
  logic [NRES_W-1:0]  n_q, n_d;

  logic               out_valid_q, out_valid_d;
  result_kind_e       kind_q, kind_d;
  logic [OWNER_W-1:0] woken_q, woken_d;
  logic               last_q, last_d;

  logic               head_ge, do_ins, do_rot;
  logic [DELAY_W-1:0] head_mod;
  logic [CW-1:0]      cnt_last;

  // neighbor of each entry toward the tail
  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_nxt
    if (gi < ENTRIES - 1) begin : g_mid
      assign nxt_delta[gi] = delta_q[gi+1];
      assign nxt_owner[gi] = owner_q[gi+1];
    end else begin : g_end
      assign nxt_delta[gi] = delta_q[gi];
      assign nxt_owner[gi] = owner_q[gi];
    end
  end

  // walk decisions: insert here, or move the head round to the tail
  assign head_ge  = delta_q[0] >= rem_q;
  assign do_ins   = cmd_i.walk_step && !ins_q && ((k_q == orig_q) || head_ge);
  assign do_rot   = cmd_i.walk_step && !do_ins;
  assign head_mod = adj_q ? delta_q[0] - rem_q : delta_q[0];
  assign cnt_last = cnt_q - CW'(1);

  // list update
  always_comb begin
    delta_d = delta_q;
    owner_d = owner_q;
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_ins && (CW'(i) == cnt_q)) begin
        delta_d[i] = rem_q;
        owner_d[i] = own_q;
      end else if (do_rot && (CW'(i) == cnt_last)) begin
        delta_d[i] = head_mod;
        owner_d[i] = owner_q[0];
      end else if (do_rot || cmd_i.pop) begin
        delta_d[i] = nxt_delta[i];
        owner_d[i] = nxt_owner[i];
      end
    end
    // tick: saturating decrement of the head
    if (cmd_i.load_tick && (delta_q[0] != '0)) begin
      delta_d[0] = delta_q[0] - DELAY_W'(1);
    end
  end

  // walk and count bookkeeping
  always_comb begin
    cnt_d  = cnt_q;
    k_d    = k_q;
    orig_d = orig_q;
    rem_d  = rem_q;
    own_d  = own_q;
    ins_d  = ins_q;
    adj_d  = adj_q;
    n_d    = n_q;
    if (cmd_i.load_insert) begin
      k_d    = '0;
      orig_d = cnt_q;
      rem_d  = delay_ticks_i;
      own_d  = owner_tag_i;
      ins_d  = 1'b0;
      adj_d  = 1'b0;
    end
    if (cmd_i.load_tick) n_d = '0;
    if (do_ins) begin
      cnt_d = cnt_q + CW'(1);
      ins_d = 1'b1;
      adj_d = 1'b1;
    end
    if (do_rot) begin
      k_d = k_q + CW'(1);
      if (!ins_q) rem_d = rem_q - delta_q[0];
      else        adj_d = 1'b0;
    end
    if (cmd_i.pop) begin
      cnt_d = cnt_q - CW'(1);
      n_d   = n_q + NRES_W'(1);
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    woken_d     = woken_q;
    last_d      = last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      kind_d      = cmd_i.emit_kind;
      woken_d     = (cmd_i.emit_kind == RK_EXPIRED) ? owner_q[0] : '0;
      last_d      = cmd_i.emit_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    owner_q <= owner_d;
    rem_q   <= rem_d;
    own_q   <= own_d;
    kind_q  <= kind_d;
    woken_q <= woken_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      k_q         <= '0;
      orig_q      <= '0;
      ins_q       <= 1'b0;
      adj_q       <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      orig_q      <= orig_d;
      ins_q       <= ins_d;
      adj_q       <= adj_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // status toward the controller
  assign sts_o.empty       = (cnt_q == '0);
  assign sts_o.full        = (cnt_q >= FullCount);
  assign sts_o.walk_done   = ins_q && (k_q == orig_q);
  assign sts_o.head_zero   = (delta_q[0] == '0);
  assign sts_o.more_expire = (cnt_q > CW'(1)) && (delta_q[1] == '0) &&
                             (n_q != NRES_W'(MAX_RESULTS - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign woken_owner_o = woken_q;
  assign last_result_o = last_q;

endmodule

/* design/dtq_ctrl.sv */
// ----------------------------------------------------------------------------
// dtq_ctrl: sequencer of the delta timer queue
// Takes one item at a time, steps the insert walk, and paces the results
// against the result register.
// ----------------------------------------------------------------------------
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     operation_i,
  output logic     in_ready_o,
  input  dtq_sts_t sts_i,
  output dtq_cmd_t cmd_o
);

  dtq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.emit_kind = RK_ACCEPTED;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (operation_i == OP_INSERT) begin
            if (sts_i.full) begin
              state_d = ST_REJECT;
            end else begin
              cmd_o.load_insert = 1'b1;
              state_d           = ST_WALK;
            end
          end else if (!sts_i.empty) begin
            cmd_o.load_tick = 1'b1;
            state_d         = ST_EXPIRE;
          end
        end
      end
      ST_WALK: begin
        if (!sts_i.walk_done) begin
          cmd_o.walk_step = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = RK_ACCEPTED;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = RK_FULL;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_EXPIRE: begin
        // first look finds nothing expired: done without a result
        if (sts_i.empty || !sts_i.head_zero) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = RK_EXPIRED;
          cmd_o.emit_last = !sts_i.more_expire;
          cmd_o.pop       = 1'b1;
          if (!sts_i.more_expire) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* design/delta_timer_queue.sv */
// ----------------------------------------------------------------------------
// delta_timer_queue: timer queue kept as a delta list
// Holds up to ENTRIES timed requests, each with an owner tag and a delay
// relative to the entry ahead of it; wakes owners as ticks run them out.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one item: operation (0 tick, 1 insert), delay_ticks and
//         owner_tag. out_o carries results: result_kind, woken_owner and
//         last_result, which marks the final result of an item.
//   An insert gives one result: accepted, or rejected when the queue is full.
//   A tick lowers the head's delta (never below zero) and gives one expired
//   result per leading zero-delta entry, up to 16; it may give none.
//   Sequence: an insert walks the list one entry per cycle and then
//   registers its result once the result register is free. A rejected
//   insert's result is registered from the reject state, once the result
//   register is free. A tick registers one expired result per cycle while
//   the result register is free; with nothing expiring it returns to idle
//   without a result.
//   One item is in work at a time; in_i is ready again once the last
//   result of the item is registered.
//   Reset empties the queue; no clearing pass is needed.
//   When the receiver stalls, the result register holds its item and the
//   sequencer waits; no result is dropped.
// ----------------------------------------------------------------------------
module delta_timer_queue
  import dtq_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  dtq_in_if.sink     in_i,
  dtq_out_if.source  out_o
);

  dtq_cmd_t cmd;
  dtq_sts_t sts;
  logic [KIND_W-1:0] kind;

  dtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dtq_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .delay_ticks_i (in_i.delay_ticks),
    .owner_tag_i   (in_i.owner_tag),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .result_kind_o (kind),
    .woken_owner_o (out_o.woken_owner),
    .last_result_o (out_o.last_result)
  );

  assign out_o.result_kind = kind;

endmodule

/* design/dtq_checker.sv */
// ----------------------------------------------------------------------------
// dtq_checker: port-level checks of the delta timer queue
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module dtq_checker
  import dtq_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_operation_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [KIND_W-1:0]  out_kind_i,
  input logic [OWNER_W-1:0] out_owner_i,
  input logic               out_last_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_kind_i) && $stable(out_owner_i) && $stable(out_last_i))
    else $error("result payload changed while stalled");

  // insert results name no owner and close their item
  a_insert_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != RK_EXPIRED) |-> (out_owner_i == '0) && out_last_i)
    else $error("insert result with owner or without last mark");

  // an accepted insert keeps the block busy in the following cycle
  a_insert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_operation_i == OP_INSERT) |=> !in_ready_i)
    else $error("next item taken right after an insert");

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_operation_i (in_i.operation),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.result_kind),
  .out_owner_i    (out_o.woken_owner),
  .out_last_i     (out_o.last_result)
);

/* verif/delta_timer_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_timer_queue_tb: self-checking bench for the delta-list timer queue
// A scoreboard class mirrors the delta list, predicts the accept, reject and
// wakeup items of every accepted request, and checks each result in order.
// Directed cases come first, then random bursts of churn, fill, drain and
// wide-delay traffic, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module delta_timer_queue_tb;
  import dtq_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned RAND_ITEMS  = 430;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_WAIT  = 40;
  // absolute delay beyond which an entry never runs out during the run
  localparam int unsigned FAR_BOUND   = 2000;

  typedef struct packed {
    result_kind_e    kind;
    logic [7:0]      owner;
    logic            last;
  } result_t;

  // Mirror of the delta list plus the queue of results still due.
  class dtq_scoreboard;
    logic [15:0] list_delta [SLOTS];
    logic [7:0]  list_owner [SLOTS];
    int unsigned list_len;
    result_t     due_results [$];
    int unsigned mismatches;

    function new();
      list_len    = 0;
      mismatches  = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function int unsigned pending();
      return due_results.size();
    endfunction

    // entries whose absolute expiry lies beyond the bound
    function int unsigned far_entries(int unsigned bound);
      int unsigned abs_t;
      int unsigned cnt;
      abs_t = 0;
      cnt   = 0;
      for (int unsigned i = 0; i < list_len; i++) begin
        abs_t += list_delta[i];
        if (abs_t > bound) cnt++;
      end
      return cnt;
    endfunction

    function void push_result(result_kind_e kind, logic [7:0] owner, logic last);
      result_t r;
      r.kind  = kind;
      r.owner = owner;
      r.last  = last;
      due_results.push_back(r);
    endfunction

    function void apply_insert(logic [15:0] delay, logic [7:0] owner);
      int unsigned pos;
      logic [15:0] rem;
      pos = 0;
      rem = delay;
      if (list_len >= SLOTS) begin
        push_result(RK_FULL, 8'h00, 1'b1);
        return;
      end
      // skip entries that run out strictly earlier
      while (pos < list_len && list_delta[pos] < rem) begin
        rem = rem - list_delta[pos];
        pos++;
      end
      for (int unsigned i = list_len; i > pos; i--) begin
        list_delta[i] = list_delta[i-1];
        list_owner[i] = list_owner[i-1];
      end
      list_delta[pos] = rem;
      list_owner[pos] = owner;
      list_len++;
      if (pos + 1 < list_len) list_delta[pos+1] = list_delta[pos+1] - rem;
      push_result(RK_ACCEPTED, 8'h00, 1'b1);
    endfunction

    function void apply_tick();
      int unsigned woken;
      woken = 0;
      if (list_len == 0) return;
      if (list_delta[0] != 0) list_delta[0] = list_delta[0] - 1'b1;
      while (list_len > 0 && list_delta[0] == 0 && woken < MAX_RESULTS) begin
        push_result(RK_EXPIRED, list_owner[0], 1'b0);
        for (int unsigned i = 1; i < list_len; i++) begin
          list_delta[i-1] = list_delta[i];
          list_owner[i-1] = list_owner[i];
        end
        list_len--;
        woken++;
      end
      if (woken > 0) due_results[due_results.size()-1].last = 1'b1;
    endfunction

    function void note_request(op_e op, logic [15:0] delay, logic [7:0] owner);
      if (op == OP_INSERT) apply_insert(delay, owner);
      else apply_tick();
    endfunction

    task check_result(logic [1:0] kind, logic [7:0] owner, logic last);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d owner %02h last %0b",
                         kind, owner, last));
        return;
      end
      want = due_results.pop_front();
      if (kind !== want.kind)
        report($sformatf("result_kind %0d, want %0d", kind, want.kind));
      if (owner !== want.owner)
        report($sformatf("woken_owner %02h, want %02h", owner, want.owner));
      if (last !== want.last)
        report($sformatf("last_result %0b, want %0b", last, want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int unsigned cycle_count = 0;
  bit sender_eager = 1'b0;

  dtq_in_if  in_if();
  dtq_out_if out_if();

  dtq_scoreboard sb = new();

  delta_timer_queue #(
    .ENTRIES(SLOTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly back-to-back or short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_eager || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_item(input op_e op, input logic [15:0] delay,
                           input logic [7:0] owner);
    int unsigned idle;
    idle = pick_gap();
    if (idle > 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.delay_ticks <= delay;
    in_if.owner_tag   <= owner;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_request(op, delay, owner);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: check accepted items, stall at random
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned calm_left;
    int unsigned results_seen;
    int unsigned r;
    bit          long_hold_done;
    hold_left      = 0;
    calm_left      = 0;
    results_seen   = 0;
    long_hold_done = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.result_kind, out_if.woken_owner, out_if.last_result);
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 40) begin
        // one long hold-off so the block backs up onto its input
        long_hold_done = 1'b1;
        hold_left      = 300;
        out_if.ready  <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          calm_left     = $urandom_range(20, 80);
          out_if.ready <= 1'b1;
        end else if (r < 28) begin
          hold_left     = (r < 25) ? $urandom_range(0, 2) : $urandom_range(15, 50);
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned counted;
    int unsigned burst;
    int unsigned mode;
    int unsigned tick_pct;
    op_e         op;
    logic [15:0] delay;
    logic [7:0]  owner;

    rst_ni = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_TICK;
    in_if.delay_ticks <= '0;
    in_if.owner_tag   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty queue, ignored fields at their top values
    send_item(OP_TICK, 16'hFFFF, 8'hFF);
    // zero delay: head already at zero stays there and expires at once
    send_item(OP_INSERT, 16'h0000, 8'hFF);
    send_item(OP_TICK, 16'h0000, 8'h00);
    // fill the queue with equal delays, lowest and highest owners included
    for (int unsigned i = 0; i < SLOTS; i++)
      send_item(OP_INSERT, 16'h0001, 8'(i * 17));
    // full queue rejects
    send_item(OP_INSERT, 16'hFFFF, 8'hAA);
    // every entry runs out on one tick
    send_item(OP_TICK, 16'h1234, 8'h5A);
    send_item(OP_INSERT, 16'hFFFF, 8'h00);
    send_item(OP_INSERT, 16'h0003, 8'h55);
    // tick with nothing expiring
    send_item(OP_TICK, 16'h0000, 8'h00);
    // equal remaining delay goes ahead of the existing entry
    send_item(OP_INSERT, 16'h0002, 8'h11);

    // sender pauses until all results are back
    in_if.valid <= 1'b0;
    wait_drained();

    counted = 0;
    burst   = 0;
    while (counted < RAND_ITEMS) begin
      mode         = $urandom_range(0, 3);
      sender_eager = ($urandom_range(0, 3) == 0);
      case (mode)
        0:       tick_pct = 45;   // churn
        1:       tick_pct = 12;   // fill up, draw rejects
        2:       tick_pct = 75;   // drain
        default: tick_pct = 35;   // wide delays
      endcase
      if (burst == 8) begin
        in_if.valid <= 1'b0;
        wait_drained();
      end
      for (int unsigned k = 0; k < 20; k++) begin
        op    = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_INSERT;
        owner = 8'($urandom_range(0, 255));
        case (mode)
          0:       delay = 16'($urandom_range(0, 6));
          1:       delay = 16'($urandom_range(0, 30));
          2:       delay = 16'($urandom_range(0, 3));
          default: begin
            // keep at most two entries that never run out
            if ($urandom_range(0, 1) == 1 && sb.far_entries(FAR_BOUND) < 2)
              delay = 16'($urandom_range(0, 65535));
            else
              delay = 16'($urandom_range(0, 10));
          end
        endcase
        if (op == OP_TICK && $urandom_range(0, 3) == 0)
          delay = 16'($urandom_range(0, 65535));
        if (!(op == OP_TICK && sb.list_len == 0)) counted++;
        send_item(op, delay, owner);
      end
      burst++;
    end
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
